/* rtl/srp_pkg.sv */
// srp_pkg: shared types, codes and constants of the sequence record parser
// used by every module of the parser and by its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

    // widths of the result fields
    localparam int unsigned READ_LENGTH_BITS = 20;
    localparam int unsigned WORD_BITS        = 32;

    // base counter width: default and widest supported value
    localparam int unsigned READ_LEN_BITS_DEFAULT = 20;
    localparam int unsigned COUNT_FIELD_BITS      = 30;

    // depth of the queue between parser front and batch back end
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // batch capacity after reset
    localparam logic [WORD_BITS-1:0] CAPACITY_RESET = 32'd16777216;

    // characters the parser looks for
    localparam logic [7:0] CHAR_FASTA_HEADER = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_SPACE        = 8'h20;  // ' '
    localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;  // '\n'
    localparam logic [7:0] CHAR_END_MARK     = 8'h45;  // 'E'

    // result item codes
    typedef enum logic [1:0] {
        KIND_NAME_BYTE   = 2'd0,
        KIND_NAME_END    = 2'd1,
        KIND_BASE        = 2'd2,
        KIND_END_OF_READ = 2'd3
    } item_kind_t;

    // input request payload
    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_end;
    } byte_item_t;

    // output request payload
    typedef struct packed {
        item_kind_t                  item_kind;
        logic [7:0]                  item_value;
        logic [READ_LENGTH_BITS-1:0] read_length;
        logic [WORD_BITS-1:0]        batch_number;
        logic [WORD_BITS-1:0]        read_in_batch;
        logic                        opens_new_batch;
        logic                        exceeds_capacity;
    } result_item_t;

    // classified event passed from front to back
    typedef struct packed {
        logic                        emit;
        item_kind_t                  kind;
        logic [7:0]                  value;
        logic [COUNT_FIELD_BITS-1:0] count;
        logic                        last;
    } event_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

/* rtl/srp_front.sv */
// srp_front: byte-level record parser that classifies each file byte
// depends on srp_pkg; pushes events into srp_queue
`timescale 1ns / 1ps
`default_nettype none

module srp_front #(
    parameter int unsigned READ_LEN_BITS = srp_pkg::READ_LEN_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    input  wire srp_pkg::byte_item_t  byte_data,
    input  wire srp_pkg::queue_status_t status,
    output logic                      push,
    output srp_pkg::event_t           push_event
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_SKIPHDR,
        PH_SEQ,
        PH_PLUS,
        PH_QUAL
    } phase_t;

    localparam logic [READ_LEN_BITS-1:0] COUNT_MAX = {READ_LEN_BITS{1'b1}};

    phase_t                   phase_reg, phase_next;
    logic                     fasta_reg, fasta_next;
    logic [READ_LEN_BITS-1:0] count_reg, count_next;
    logic [READ_LEN_BITS:0]   skip_reg, skip_next;
    logic [READ_LEN_BITS:0]   skip_dec;
    logic                     accept;
    logic [7:0]               b;
    srp_pkg::event_t          ev;

    assign accept = byte_valid && !status.full;
    assign b      = byte_data.file_byte;
    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    // next parse state and event for the current byte
    always_comb
    begin
        phase_next = phase_reg;
        fasta_next = fasta_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        ev         = '0;
        ev.count   = srp_pkg::COUNT_FIELD_BITS'(count_reg);
        ev.last    = byte_data.file_end;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    fasta_next = (b == srp_pkg::CHAR_FASTA_HEADER);
                    count_next = '0;
                    skip_next  = '0;
                    phase_next = PH_NAME;
                end
                PH_NAME:
                begin
                    ev.emit = 1'b1;
                    if (b == srp_pkg::CHAR_SPACE || b == srp_pkg::CHAR_NEWLINE)
                    begin
                        ev.kind    = srp_pkg::KIND_NAME_END;
                        phase_next = (b == srp_pkg::CHAR_NEWLINE) ? PH_SEQ : PH_SKIPHDR;
                    end
                    else
                    begin
                        ev.kind  = srp_pkg::KIND_NAME_BYTE;
                        ev.value = b;
                    end
                end
                PH_SKIPHDR:
                begin
                    if (b == srp_pkg::CHAR_NEWLINE)
                        phase_next = PH_SEQ;
                end
                PH_SEQ:
                begin
                    ev.emit = 1'b1;
                    if (b == srp_pkg::CHAR_NEWLINE)
                    begin
                        ev.kind    = srp_pkg::KIND_END_OF_READ;
                        ev.value   = srp_pkg::CHAR_END_MARK;
                        phase_next = fasta_reg ? PH_HEADER : PH_PLUS;
                    end
                    else
                    begin
                        ev.kind  = srp_pkg::KIND_BASE;
                        ev.value = b;
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                end
                PH_PLUS:
                begin
                    if (b == srp_pkg::CHAR_NEWLINE)
                    begin
                        skip_next  = {1'b0, count_reg} + 1'b1;
                        phase_next = PH_QUAL;
                    end
                end
                PH_QUAL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
            // file end drops any open record
            if (byte_data.file_end)
            begin
                phase_next = PH_HEADER;
                fasta_next = 1'b0;
                count_next = '0;
                skip_next  = '0;
            end
        end
    end

    assign push       = accept && (ev.emit || ev.last);
    assign push_event = ev;

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fasta_reg <= 1'b0;
            count_reg <= '0;
            skip_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fasta_reg <= fasta_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/srp_queue.sv */
// srp_queue: short event queue between parser front and batch back end
// depends on srp_pkg for the event type
`timescale 1ns / 1ps
`default_nettype none

module srp_queue #(
    parameter int unsigned DEPTH = srp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire srp_pkg::event_t  push_event,
    input  wire logic             pop,
    output srp_pkg::event_t       head,
    output srp_pkg::queue_status_t status
);

    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    srp_pkg::event_t     slots [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // event storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_event;
    end

endmodule

`default_nettype wire

/* rtl/srp_back.sv */
// srp_back: batch packing of finished reads and the registered result output
// depends on srp_pkg; pops events from srp_queue
`timescale 1ns / 1ps
`default_nettype none

module srp_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   capacity_we,
    input  wire logic [31:0]            capacity_wdata,
    input  wire srp_pkg::event_t        head,
    input  wire srp_pkg::queue_status_t status,
    output logic                        pop,
    output logic                        item_valid,
    input  wire logic                   item_stall,
    output srp_pkg::result_item_t       item_data
);

    localparam int unsigned W  = srp_pkg::WORD_BITS;
    localparam int unsigned CB = srp_pkg::COUNT_FIELD_BITS;
    localparam int unsigned LB = srp_pkg::READ_LENGTH_BITS;

    logic [W-1:0]          capacity_reg;
    logic [W-1:0]          fill_reg, fill_next;
    logic [W-1:0]          batch_reg, batch_next;
    logic [W-1:0]          reads_reg, reads_next;
    logic                  valid_reg, valid_next;
    srp_pkg::result_item_t data_reg, data_next;

    logic [W:0]            size, cap_ext, sum_cur, base_fill, sum_new;
    logic                  exceeds, opens, is_eor, emit_now;
    logic [W-1:0]          batch_after, reads_base;
    logic [LB-1:0]         length_sat;

    // pop when the event needs no output slot or the slot frees up
    assign pop      = !status.empty && (!head.emit || !valid_reg || !item_stall);
    assign emit_now = pop && head.emit;
    assign is_eor   = (head.kind == srp_pkg::KIND_END_OF_READ);

    // read cost against capacity
    assign size      = (W + 1)'(head.count) + 1'b1;
    assign cap_ext   = {1'b0, capacity_reg};
    assign exceeds   = (size > cap_ext);
    assign sum_cur   = {1'b0, fill_reg} + size;
    assign opens     = (reads_reg != '0) && (sum_cur > cap_ext);
    assign base_fill = opens ? '0 : {1'b0, fill_reg};
    assign sum_new   = base_fill + size;
    assign batch_after = batch_reg + W'(opens);
    assign reads_base  = opens ? '0 : reads_reg;

    // reported length saturates at the field maximum
    assign length_sat = (|head.count[CB-1:LB]) ? {LB{1'b1}} : head.count[LB-1:0];

    // batch bookkeeping and result build
    always_comb
    begin
        fill_next  = fill_reg;
        batch_next = batch_reg;
        reads_next = reads_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (emit_now)
        begin
            valid_next           = 1'b1;
            data_next            = '0;
            data_next.item_kind  = head.kind;
            data_next.item_value = head.value;
            if (is_eor)
            begin
                data_next.read_length      = length_sat;
                data_next.batch_number     = batch_after;
                data_next.read_in_batch    = reads_base;
                data_next.opens_new_batch  = opens;
                data_next.exceeds_capacity = exceeds;
                batch_next = batch_after;
                fill_next  = sum_new[W] ? {W{1'b1}} : sum_new[W-1:0];
                reads_next = reads_base + 1'b1;
            end
        end
        else if (!item_stall)
        begin
            valid_next = 1'b0;
        end
        // file end closes the batch
        if (pop && head.last)
        begin
            batch_next = batch_next + 1'b1;
            fill_next  = '0;
            reads_next = '0;
        end
    end

    // control and batch registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= srp_pkg::CAPACITY_RESET;
            fill_reg     <= '0;
            batch_reg    <= '0;
            reads_reg    <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (capacity_we)
                capacity_reg <= capacity_wdata;
            fill_reg  <= fill_next;
            batch_reg <= batch_next;
            reads_reg <= reads_next;
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/sequence_record_parser.sv */
// sequence_record_parser: FASTA/FASTQ byte parser with batch packing of reads
// throughput one file byte per cycle while byte_stall is low; a result from a taken byte
// reaches item_valid through the event queue, then the output register
// an event queue, four entries by default, lets either side stall without stopping the other
// asynchronous reset clears parse, queue and batch state; capacity returns to 2^24
`timescale 1ns / 1ps
`default_nettype none

module sequence_record_parser #(
    parameter int unsigned READ_LEN_BITS = srp_pkg::READ_LEN_BITS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH   = srp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  capacity_we,
    input  wire logic [31:0]           capacity_wdata,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire srp_pkg::byte_item_t   byte_data,
    output logic                       item_valid,
    input  wire logic                  item_stall,
    output srp_pkg::result_item_t      item_data
);

    srp_pkg::queue_status_t status;
    srp_pkg::event_t        push_event;
    srp_pkg::event_t        head;
    logic                   push, pop;

    assign byte_stall = status.full;

    // parse front
    srp_front #(
        .READ_LEN_BITS(READ_LEN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_data (byte_data),
        .status    (status),
        .push      (push),
        .push_event(push_event)
    );

    // event queue
    srp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_event(push_event),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    // batch back end
    srp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_we   (capacity_we),
        .capacity_wdata(capacity_wdata),
        .head          (head),
        .status        (status),
        .pop           (pop),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item_data     (item_data)
    );

endmodule

`default_nettype wire

/* rtl/srp_checker.sv */
// srp_checker: port-level checks on the result channel of the parser
// depends on srp_pkg; bound to sequence_record_parser
`timescale 1ns / 1ps
`default_nettype none

module srp_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_stall,
    input wire srp_pkg::result_item_t item_data
);

    // stalled result request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item_data))
        else $error("stalled result changed");

    // end of read carries the end mark
    a_eor_mark: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_data.item_kind == srp_pkg::KIND_END_OF_READ
        |-> item_data.item_value == srp_pkg::CHAR_END_MARK)
        else $error("end of read without end mark");

    // read fields stay clear on other items
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_data.item_kind != srp_pkg::KIND_END_OF_READ
        |-> item_data.read_length == '0 && item_data.batch_number == '0
            && item_data.read_in_batch == '0 && !item_data.opens_new_batch
            && !item_data.exceeds_capacity)
        else $error("batch fields set on non-read item");

    // a read that opens a batch is first in it
    a_open_first: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_data.opens_new_batch |-> item_data.read_in_batch == '0)
        else $error("new batch read not first");

endmodule

bind sequence_record_parser srp_checker u_srp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item_data (item_data)
);

`default_nettype wire
